### rtl/tcfc_pkg.sv
// shared constants and control types for the four-corner touch calibrator
`default_nettype none

package tcfc_pkg;

    localparam int          RAW_BITS_DEF = 12;
    localparam int          CNT_W        = 3;
    localparam int          CHECK_W      = 16;
    localparam int          NUM_CORNERS  = 4;
    localparam logic [2:0]  CORNERS      = 3'd4;
    localparam logic [15:0] CHECK_SEED   = 16'hCAFE;

    // per-word control from the input stage to the sequencer
    typedef struct packed {
        logic step;
        logic start;
        logic touch;
    } ctl_t;

endpackage

`default_nettype wire

### rtl/tcfc_bounds.sv
// pair averaging, ordering and checksum of the four captured corners
`default_nettype none

module tcfc_bounds
    import tcfc_pkg::*;
#(
    parameter int RAW_BITS = RAW_BITS_DEF
) (
    input  wire logic [RAW_BITS-1:0] cx [NUM_CORNERS],
    input  wire logic [RAW_BITS-1:0] cy [NUM_CORNERS],
    output logic      [RAW_BITS-1:0] x_lo,
    output logic      [RAW_BITS-1:0] x_hi,
    output logic      [RAW_BITS-1:0] y_lo,
    output logic      [RAW_BITS-1:0] y_hi,
    output logic      [CHECK_W-1:0]  chk
);

    localparam int SW = (RAW_BITS + 2 > CHECK_W) ? RAW_BITS + 2 : CHECK_W;

    logic [RAW_BITS:0]   left_sum;
    logic [RAW_BITS:0]   right_sum;
    logic [RAW_BITS:0]   top_sum;
    logic [RAW_BITS:0]   bot_sum;
    logic [RAW_BITS-1:0] left;
    logic [RAW_BITS-1:0] right;
    logic [RAW_BITS-1:0] top;
    logic [RAW_BITS-1:0] bottom;
    logic [SW-1:0]       total;

    // corner order: top-left, top-right, bottom-right, bottom-left
    assign left_sum  = {1'b0, cx[0]} + {1'b0, cx[3]};
    assign right_sum = {1'b0, cx[1]} + {1'b0, cx[2]};
    assign top_sum   = {1'b0, cy[0]} + {1'b0, cy[1]};
    assign bot_sum   = {1'b0, cy[2]} + {1'b0, cy[3]};

    assign left   = left_sum[RAW_BITS:1];
    assign right  = right_sum[RAW_BITS:1];
    assign top    = top_sum[RAW_BITS:1];
    assign bottom = bot_sum[RAW_BITS:1];

    assign x_lo = (left < right) ? left : right;
    assign x_hi = (left < right) ? right : left;
    assign y_lo = (top < bottom) ? top : bottom;
    assign y_hi = (top < bottom) ? bottom : top;

    // ordering does not change the sum, so add the averages directly
    assign total = SW'(left) + SW'(right) + SW'(top) + SW'(bottom) + SW'(CHECK_SEED);
    assign chk   = total[CHECK_W-1:0];

endmodule

`default_nettype wire

### rtl/tcfc_seq.sv
// calibration sequencer: arming, touch hold, corner capture and bound registers
`default_nettype none

module tcfc_seq
    import tcfc_pkg::*;
#(
    parameter int RAW_BITS = RAW_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctl_t                ctl,
    input  wire logic [RAW_BITS-1:0] rx,
    input  wire logic [RAW_BITS-1:0] ry,
    output logic                     done_nx,
    output logic      [CNT_W-1:0]    taken_nx,
    output logic      [RAW_BITS-1:0] xl_nx,
    output logic      [RAW_BITS-1:0] xh_nx,
    output logic      [RAW_BITS-1:0] yl_nx,
    output logic      [RAW_BITS-1:0] yh_nx,
    output logic      [CHECK_W-1:0]  chk_nx
);

    logic                active_reg;
    logic                finished_reg;
    logic                was_pressed_reg;
    logic [CNT_W-1:0]    corner_index_reg;
    logic [RAW_BITS-1:0] held_x_reg;
    logic [RAW_BITS-1:0] held_y_reg;
    logic [RAW_BITS-1:0] corner_x_reg [NUM_CORNERS];
    logic [RAW_BITS-1:0] corner_y_reg [NUM_CORNERS];
    logic [RAW_BITS-1:0] xl_reg;
    logic [RAW_BITS-1:0] xh_reg;
    logic [RAW_BITS-1:0] yl_reg;
    logic [RAW_BITS-1:0] yh_reg;
    logic [CHECK_W-1:0]  chk_reg;

    logic                active_next;
    logic                finished_next;
    logic                was_pressed_next;
    logic [CNT_W-1:0]    corner_index_next;
    logic                act_eff;
    logic                fin_eff;
    logic [CNT_W-1:0]    idx_eff;
    logic                run;
    logic                capture;
    logic                release_pt;
    logic                finishing;
    logic [1:0]          slot;
    logic [RAW_BITS-1:0] cx_eff [NUM_CORNERS];
    logic [RAW_BITS-1:0] cy_eff [NUM_CORNERS];
    logic [RAW_BITS-1:0] b_xl;
    logic [RAW_BITS-1:0] b_xh;
    logic [RAW_BITS-1:0] b_yl;
    logic [RAW_BITS-1:0] b_yh;
    logic [CHECK_W-1:0]  b_chk;
    logic [RAW_BITS-1:0] xl_next;
    logic [RAW_BITS-1:0] xh_next;
    logic [RAW_BITS-1:0] yl_next;
    logic [RAW_BITS-1:0] yh_next;
    logic [CHECK_W-1:0]  chk_next;

    // start re-arms first, then the same poll runs through the sequence
    assign act_eff = ctl.start | active_reg;
    assign fin_eff = ctl.start ? 1'b0 : finished_reg;
    assign idx_eff = ctl.start ? '0 : corner_index_reg;
    assign run     = act_eff & ~fin_eff;

    assign capture    = run & ctl.touch;
    assign release_pt = run & ~ctl.touch & was_pressed_reg;
    assign slot       = idx_eff[1:0];

    assign corner_index_next = release_pt ? idx_eff + CNT_W'(1) : idx_eff;
    assign finishing         = release_pt & (corner_index_next == CORNERS);
    assign active_next       = finishing ? 1'b0 : act_eff;
    assign finished_next     = fin_eff | finishing;
    assign was_pressed_next  = capture ? 1'b1 : (release_pt ? 1'b0 : was_pressed_reg);

    // corner values as they stand after this poll's write
    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            if (release_pt && slot == 2'(i))
            begin
                cx_eff[i] = held_x_reg;
                cy_eff[i] = held_y_reg;
            end
            else
            begin
                cx_eff[i] = corner_x_reg[i];
                cy_eff[i] = corner_y_reg[i];
            end
        end
    end

    tcfc_bounds #(
        .RAW_BITS (RAW_BITS)
    ) u_bounds (
        .cx   (cx_eff),
        .cy   (cy_eff),
        .x_lo (b_xl),
        .x_hi (b_xh),
        .y_lo (b_yl),
        .y_hi (b_yh),
        .chk  (b_chk)
    );

    assign xl_next  = finishing ? b_xl  : xl_reg;
    assign xh_next  = finishing ? b_xh  : xh_reg;
    assign yl_next  = finishing ? b_yl  : yl_reg;
    assign yh_next  = finishing ? b_yh  : yh_reg;
    assign chk_next = finishing ? b_chk : chk_reg;

    // result word of this poll, bounds read as zero until done
    assign done_nx  = finished_next;
    assign taken_nx = corner_index_next;
    assign xl_nx    = finished_next ? xl_next  : '0;
    assign xh_nx    = finished_next ? xh_next  : '0;
    assign yl_nx    = finished_next ? yl_next  : '0;
    assign yh_nx    = finished_next ? yh_next  : '0;
    assign chk_nx   = finished_next ? chk_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            finished_reg     <= 1'b0;
            was_pressed_reg  <= 1'b0;
            corner_index_reg <= '0;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            xl_reg           <= '0;
            xh_reg           <= '0;
            yl_reg           <= '0;
            yh_reg           <= '0;
            chk_reg          <= '0;
        end
        else if (ctl.step)
        begin
            active_reg       <= active_next;
            finished_reg     <= finished_next;
            was_pressed_reg  <= was_pressed_next;
            corner_index_reg <= corner_index_next;
            if (capture)
            begin
                held_x_reg <= rx;
                held_y_reg <= ry;
            end
            xl_reg  <= xl_next;
            xh_reg  <= xh_next;
            yl_reg  <= yl_next;
            yh_reg  <= yh_next;
            chk_reg <= chk_next;
        end
    end

    // corner store, no reset: only read after all four are written
    always_ff @(posedge clk)
    begin
        if (ctl.step && release_pt)
        begin
            corner_x_reg[slot] <= held_x_reg;
            corner_y_reg[slot] <= held_y_reg;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        corner_index_reg <= CORNERS)
        else $error("corner index beyond four");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !active_reg && corner_index_reg == CORNERS)
        else $error("finished while still armed or short of corners");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg && !ctl.start |=> finished_reg)
        else $error("done dropped without a start");

endmodule

`default_nettype wire

### rtl/touch_four_corner_calibrator.sv
// Four-corner touch-panel calibrator.
// One input word is one panel poll: start_req, touching, raw_x, raw_y.
// start_req arms the sequence at corner 0; while touching the last raw pair
// is held, and on release it is stored as the next corner. After the fourth
// corner the averaged, ordered bounds and their checksum are reported.
// Channels: poll (poll_valid / poll_stall) and result (result_valid /
// result_stall); a word moves on an edge with valid high and stall low.
// Every poll gives exactly one result word.
// A poll passes the input register, then sequencer logic into the result
// register; result_valid is that register's valid flag.
// One poll per cycle while result_stall is low; the input and result
// registers form a two-stage pipe, so a poll is taken while a result waits.
// When result_stall is held, the result register holds its word, the input
// register fills, and poll_stall then rises until the result is taken.
// Reset (rst_n low, asynchronous): both stages empty, sequence disarmed,
// corner count and bounds cleared.
`default_nettype none

module touch_four_corner_calibrator
    import tcfc_pkg::*;
#(
    parameter int RAW_BITS = RAW_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                poll_valid,
    output logic                     poll_stall,
    input  wire logic                start_req,
    input  wire logic                touching,
    input  wire logic [RAW_BITS-1:0] raw_x,
    input  wire logic [RAW_BITS-1:0] raw_y,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic                     done_res,
    output logic      [CNT_W-1:0]    corners_taken,
    output logic      [RAW_BITS-1:0] x_low,
    output logic      [RAW_BITS-1:0] x_high,
    output logic      [RAW_BITS-1:0] y_low,
    output logic      [RAW_BITS-1:0] y_high,
    output logic      [CHECK_W-1:0]  check_word
);

    logic                in_vld_reg;
    logic                in_start_reg;
    logic                in_touch_reg;
    logic [RAW_BITS-1:0] in_x_reg;
    logic [RAW_BITS-1:0] in_y_reg;
    logic                out_vld_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    taken_reg;
    logic [RAW_BITS-1:0] xl_reg;
    logic [RAW_BITS-1:0] xh_reg;
    logic [RAW_BITS-1:0] yl_reg;
    logic [RAW_BITS-1:0] yh_reg;
    logic [CHECK_W-1:0]  chk_reg;

    logic                in_vld_next;
    logic                out_vld_next;
    logic                accept;
    logic                advance;
    logic                out_take;
    ctl_t                ctl;
    logic                done_nx;
    logic [CNT_W-1:0]    taken_nx;
    logic [RAW_BITS-1:0] xl_nx;
    logic [RAW_BITS-1:0] xh_nx;
    logic [RAW_BITS-1:0] yl_nx;
    logic [RAW_BITS-1:0] yh_nx;
    logic [CHECK_W-1:0]  chk_nx;

    assign out_take   = out_vld_reg & ~result_stall;
    assign advance    = in_vld_reg & (~out_vld_reg | ~result_stall);
    assign poll_stall = in_vld_reg & ~advance;
    assign accept     = poll_valid & ~poll_stall;

    assign in_vld_next  = accept | (in_vld_reg & ~advance);
    assign out_vld_next = advance | (out_vld_reg & ~out_take);

    assign ctl.step  = advance;
    assign ctl.start = in_start_reg;
    assign ctl.touch = in_touch_reg;

    tcfc_seq #(
        .RAW_BITS (RAW_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rx       (in_x_reg),
        .ry       (in_y_reg),
        .done_nx  (done_nx),
        .taken_nx (taken_nx),
        .xl_nx    (xl_nx),
        .xh_nx    (xh_nx),
        .yl_nx    (yl_nx),
        .yh_nx    (yh_nx),
        .chk_nx   (chk_nx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_start_reg <= start_req;
            in_touch_reg <= touching;
            in_x_reg     <= raw_x;
            in_y_reg     <= raw_y;
        end
        if (advance)
        begin
            done_reg  <= done_nx;
            taken_reg <= taken_nx;
            xl_reg    <= xl_nx;
            xh_reg    <= xh_nx;
            yl_reg    <= yl_nx;
            yh_reg    <= yh_nx;
            chk_reg   <= chk_nx;
        end
    end

    assign result_valid  = out_vld_reg;
    assign done_res      = done_reg;
    assign corners_taken = taken_reg;
    assign x_low         = xl_reg;
    assign x_high        = xh_reg;
    assign y_low         = yl_reg;
    assign y_high        = yh_reg;
    assign check_word    = chk_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        poll_stall |-> in_vld_reg && out_vld_reg && result_stall)
        else $error("poll stalled with room in the pipe");

    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && done_res |-> corners_taken == CORNERS)
        else $error("done word without four corners");

    a_zero_before_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !done_res |-> check_word == '0 && x_low == '0 && y_high == '0)
        else $error("bounds shown before done");

endmodule

`default_nettype wire
